[src/bafind_pkg.sv]
// Shared types and constants for the bitmap find-first block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package bafind_pkg;

    localparam int CAPACITY_BITS = 4096;
    localparam int FUNC_W        = 3;
    localparam int IDX_W         = $clog2(CAPACITY_BITS);
    localparam int COUNT_W       = $clog2(CAPACITY_BITS + 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE     = 3'd0,
        FN_READ      = 3'd1,
        FN_FIND_SET  = 3'd2,
        FN_FIND_CLR  = 3'd3,
        FN_APPEND    = 3'd4,
        FN_DROP      = 3'd5,
        FN_FILL      = 3'd6
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_FILL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_START,
        PTR_APPEND,
        PTR_ZERO,
        PTR_NEXT
    } t_ptr_op;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC
    } t_len_op;

    typedef enum logic {
        WR_BIT,
        WR_FILL
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        t_ptr_op ptr_op;
        t_len_op len_op;
        logic    mem_we;
        t_wr_sel wr_sel;
        logic    st_err;
        logic    st_read;
        logic    st_found;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  idx_oob;
        logic  len_zero;
        logic  len_full;
        logic  hit;
        logic  at_last;
    } t_dp_sts;

    typedef struct packed {
        logic               read_value;
        logic               found;
        logic [IDX_W-1:0]   found_index;
        logic [COUNT_W-1:0] bit_count;
        logic               error;
    } t_rsp;

endpackage

[src/bafind_req_if.sv]
// Request channel: operation code, bit index and bit value with valid/ready.
// Depends on bafind_pkg for field widths.
interface bafind_req_if;
    import bafind_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  bit_index;
    logic              bit_value;

    modport source (output valid, func, bit_index, bit_value, input ready);
    modport sink   (input valid, func, bit_index, bit_value, output ready);
endinterface

[src/bafind_rsp_if.sv]
// Result channel: read bit, search result, length and error flag with valid/ready.
// Depends on bafind_pkg for field widths.
interface bafind_rsp_if;
    import bafind_pkg::*;

    logic               valid;
    logic               ready;
    logic               read_value;
    logic               found;
    logic [IDX_W-1:0]   found_index;
    logic [COUNT_W-1:0] bit_count;
    logic               error;

    modport source (output valid, read_value, found, found_index, bit_count, error,
                    input ready);
    modport sink   (input valid, read_value, found, found_index, bit_count, error,
                    output ready);
endinterface

[src/bit_array_find_first.sv]
// Top level of the growable bitmap with find-first-set/clear search.
// Depends on bafind_pkg, bafind_req_if, bafind_rsp_if, bafind_ctrl and bafind_dp.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-------------------------------------------
//   i_req    | in  | valid/ready       | func, bit_index, bit_value
//   o_rsp    | out | valid/ready       | read_value, found, found_index, bit_count,
//            |     |                   | error
//
// One item at a time; i_req.ready is high only while the controller is idle.
// Drop and rejected items finish after decode; read, write and append take one
// registered word read; a search scans one word per cycle, up to
// CAPACITY_BITS / WORD_BITS words, and a fill writes every word in use.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its own completion stalls on o_rsp.ready.
// Synchronous active-low reset clears the length and the control state; the word
// memory needs no clearing since append zeroes a fresh word before use.
// WORD_BITS must be a power of two.
module bit_array_find_first #(
    parameter int WORD_BITS     = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bafind_req_if.sink    i_req,
    bafind_rsp_if.source  o_rsp
);
    import bafind_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_rsp    rsp;
    logic    in_ready;
    logic    out_valid;

    bafind_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bafind_dp #(
        .WORD_BITS     (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_req.func),
        .i_bit_index (i_req.bit_index),
        .i_bit_value (i_req.bit_value),
        .o_sts       (sts),
        .o_rsp       (rsp)
    );

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = out_valid;
    assign o_rsp.read_value  = rsp.read_value;
    assign o_rsp.found       = rsp.found;
    assign o_rsp.found_index = rsp.found_index;
    assign o_rsp.bit_count   = rsp.bit_count;
    assign o_rsp.error       = rsp.error;

endmodule

[src/bafind_ctrl.sv]
// Controller state machine: sequences decode, word access, search scan and fill sweep.
// Depends on bafind_pkg for state, command and status types.
module bafind_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  bafind_pkg::t_dp_sts i_sts,
    output bafind_pkg::t_dp_cmd o_cmd
);
    import bafind_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    FN_WRITE, FN_READ, FN_FIND_SET, FN_FIND_CLR: begin
                        n_state = i_sts.idx_oob ? S_DONE : S_EXEC;
                    end
                    FN_APPEND: n_state = i_sts.len_full ? S_DONE : S_EXEC;
                    FN_FILL:   n_state = i_sts.len_zero ? S_DONE : S_FILL;
                    default:   n_state = S_DONE;
                endcase
            end
            S_EXEC: begin
                if ((i_sts.func == FN_FIND_SET || i_sts.func == FN_FIND_CLR)
                        && !i_sts.hit && !i_sts.at_last) begin
                    n_state = S_EXEC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FILL: begin
                if (i_sts.at_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.ptr_op   = PTR_HOLD;
        o_cmd.len_op   = LEN_HOLD;
        o_cmd.wr_sel   = WR_BIT;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    FN_WRITE, FN_READ, FN_FIND_SET, FN_FIND_CLR: begin
                        o_cmd.st_err = i_sts.idx_oob;
                        o_cmd.ptr_op = PTR_START;
                    end
                    FN_APPEND: begin
                        o_cmd.st_err = i_sts.len_full;
                        o_cmd.ptr_op = PTR_APPEND;
                    end
                    FN_DROP: begin
                        o_cmd.st_err = i_sts.len_zero;
                        o_cmd.len_op = i_sts.len_zero ? LEN_HOLD : LEN_DEC;
                    end
                    FN_FILL: begin
                        o_cmd.ptr_op = PTR_ZERO;
                    end
                    default: o_cmd.st_err = 1'b1;
                endcase
            end
            S_EXEC: begin
                unique case (i_sts.func)
                    FN_READ:  o_cmd.st_read = 1'b1;
                    FN_WRITE: o_cmd.mem_we  = 1'b1;
                    FN_APPEND: begin
                        o_cmd.mem_we = 1'b1;
                        o_cmd.len_op = LEN_INC;
                    end
                    FN_FIND_SET, FN_FIND_CLR: begin
                        o_cmd.st_found = i_sts.hit;
                        if (!i_sts.hit && !i_sts.at_last) begin
                            o_cmd.ptr_op = PTR_NEXT;
                        end
                    end
                    default: o_cmd.st_err = 1'b0;
                endcase
            end
            S_FILL: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wr_sel = WR_FILL;
                if (!i_sts.at_last) begin
                    o_cmd.ptr_op = PTR_NEXT;
                end
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: o_cmd.load = 1'b0;
        endcase
    end

endmodule

[src/bafind_dp.sv]
// Datapath: word memory, length counter, word pointer, bit update, masked search
// and result registers. Depends on bafind_pkg; driven by bafind_ctrl commands.
module bafind_dp #(
    parameter int WORD_BITS     = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bafind_pkg::t_dp_cmd              i_cmd,
    input  logic [bafind_pkg::FUNC_W-1:0]    i_func,
    input  logic [bafind_pkg::IDX_W-1:0]     i_bit_index,
    input  logic                             i_bit_value,
    output bafind_pkg::t_dp_sts              o_sts,
    output bafind_pkg::t_rsp                 o_rsp
);
    import bafind_pkg::*;

    localparam int NUM_WORDS = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WS        = $clog2(WORD_BITS);
    localparam int LW        = $clog2(CAPACITY_BITS + 1);
    localparam int CW        = (LW > IDX_W) ? LW : IDX_W;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [FUNC_W-1:0] r_func;
    logic [IDX_W-1:0]  r_index;
    logic              r_value;
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     n_len;
    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     n_ptr;

    logic              r_st_rd;
    logic              r_st_found;
    logic [IDX_W-1:0]  r_st_fidx;
    logic              r_st_err;
    t_rsp              r_out;

    t_func             func;
    logic [LW-1:0]     len_m1;
    logic [AW-1:0]     start_word;
    logic [AW-1:0]     last_word;
    logic [AW-1:0]     append_word;
    logic [WS-1:0]     start_bit;
    logic [WS-1:0]     last_bit;
    logic [WS-1:0]     len_bit;
    logic [WS-1:0]     wr_bit;
    logic [WORD_BITS-1:0] base_word;
    logic [WORD_BITS-1:0] wr_word;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] match;
    logic [WORD_BITS-1:0] first_one;
    logic [WS-1:0]        pos;

    assign func        = t_func'(r_func);
    assign len_m1      = r_len - LW'(1);
    assign start_word  = AW'(r_index >> WS);
    assign last_word   = AW'(len_m1 >> WS);
    assign append_word = AW'(r_len >> WS);
    assign start_bit   = r_index[WS-1:0];
    assign last_bit    = len_m1[WS-1:0];
    assign len_bit     = r_len[WS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_index <= i_bit_index;
            r_value <= i_bit_value;
        end
    end

    // word pointer; the memory reads at the pointer's next value
    always_comb begin
        unique case (i_cmd.ptr_op)
            PTR_START:  n_ptr = start_word;
            PTR_APPEND: n_ptr = append_word;
            PTR_ZERO:   n_ptr = '0;
            PTR_NEXT:   n_ptr = r_ptr + AW'(1);
            default:    n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
    end

    always_comb begin
        unique case (i_cmd.len_op)
            LEN_INC: n_len = r_len + LW'(1);
            LEN_DEC: n_len = r_len - LW'(1);
            default: n_len = r_len;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    // single bit update; a fresh word on append starts from zero
    always_comb begin
        wr_bit    = (func == FN_APPEND) ? len_bit : start_bit;
        base_word = (func == FN_APPEND && len_bit == '0) ? '0 : r_rd_data;
        wr_word   = (base_word & ~(WORD_BITS'(1) << wr_bit))
                  | (WORD_BITS'(r_value) << wr_bit);
        wr_data   = (i_cmd.wr_sel == WR_FILL) ? {WORD_BITS{r_value}} : wr_word;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[r_ptr] <= wr_data;
        end
        r_rd_data <= r_mem[n_ptr];
    end

    // search window: from the start bit in the first word up to length - 1
    always_comb begin
        cand      = (func == FN_FIND_SET) ? r_rd_data : ~r_rd_data;
        lo_mask   = (r_ptr == start_word) ? (ONES << start_bit) : ONES;
        hi_mask   = (r_ptr == last_word) ? (ONES >> (~last_bit)) : ONES;
        match     = cand & lo_mask & hi_mask;
        first_one = match & (~match + WORD_BITS'(1));
        pos       = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (first_one[b]) begin
                pos = pos | WS'(b);
            end
        end
    end

    assign o_sts.func     = func;
    assign o_sts.idx_oob  = (CW'(r_index) >= CW'(r_len));
    assign o_sts.len_zero = (r_len == '0);
    assign o_sts.len_full = (r_len >= LW'(CAPACITY_BITS));
    assign o_sts.hit      = |match;
    assign o_sts.at_last  = (r_ptr == last_word);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_st_rd    <= 1'b0;
            r_st_found <= 1'b0;
            r_st_fidx  <= '0;
            r_st_err   <= 1'b0;
        end else begin
            if (i_cmd.st_err) begin
                r_st_err <= 1'b1;
            end
            if (i_cmd.st_read) begin
                r_st_rd <= r_rd_data[start_bit];
            end
            if (i_cmd.st_found) begin
                r_st_found <= 1'b1;
                r_st_fidx  <= IDX_W'({r_ptr, pos});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.read_value  <= r_st_rd;
            r_out.found       <= r_st_found;
            r_out.found_index <= r_st_fidx;
            r_out.bit_count   <= COUNT_W'(r_len);
            r_out.error       <= r_st_err;
        end
    end

    assign o_rsp = r_out;

endmodule
